FILE: hw/rtl/gha_pkg.sv
// Shared types, constants and the GF(2^128) digit step for the GHASH accumulator.
// Used by gha_in_queue, gha_mult_engine and ghash_accumulator_unit; no dependencies.
package gha_pkg;

    localparam int GH_W     = 128;
    localparam int HALF_W   = 64;
    localparam int DIGIT_W  = 8;
    localparam int N_DIGITS = GH_W / DIGIT_W;
    localparam int STEP_W   = $clog2(N_DIGITS);

    // Reduction polynomial in the GCM bit-reflected order: 0xE1 then 120 zeros.
    localparam logic [GH_W-1:0] GH_R = {8'b11100001, {(GH_W-8){1'b0}}};

    // Configuration register indexes.
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_HIGH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_LOW  = 2'd1;

    // One queued data block; block holds byte 0 in bits 127:120.
    typedef struct packed {
        logic [GH_W-1:0] block;
        logic            start;
    } t_gh_item;

    typedef struct packed {
        logic [GH_W-1:0] z;
        logic [GH_W-1:0] v;
    } t_gf_pair;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_BUSY,
        ST_WAIT
    } t_eng_state;

    // Absorb DIGIT_W multiplier bits, most significant first: conditional add of V,
    // then V times x with reduction.
    function automatic t_gf_pair gf_digit(input logic [GH_W-1:0] z,
                                          input logic [GH_W-1:0] v,
                                          input logic [DIGIT_W-1:0] d);
        t_gf_pair   p;
        logic       carry;
        p.z = z;
        p.v = v;
        for (int j = 0; j < DIGIT_W; j++) begin
            if (d[DIGIT_W-1-j]) begin
                p.z = p.z ^ p.v;
            end
            carry = p.v[0];
            p.v   = p.v >> 1;
            if (carry) begin
                p.v = p.v ^ GH_R;
            end
        end
        return p;
    endfunction

endpackage

FILE: hw/rtl/ghash_accumulator_unit.sv
// GHASH accumulator top level: key registers, input queue and multiply engine.
// Depends on gha_pkg, gha_in_queue and gha_mult_engine.
//
//  channel   direction  handshake                 payload
//  s_axis    in         s_axis_tvalid/tready      tdata = block_high, block_low; tuser = start_req
//  m_axis    out        m_axis_tvalid/tready      tdata = digest_high, digest_low
//  cfg       in         i_cfg_valid/o_cfg_ready   i_cfg_index, i_cfg_data (key halves)
//
// The multiply walks the 128-bit multiplier 8 bits a cycle, and each block
// needs the previous accumulator, so a new block starts only once the last
// multiply is done. From an idle start a block passes the queue, the 16
// digit steps and the output register.
// Reset (i_rst_n low at a clock edge) clears the keys, accumulator, queue and
// output valid. The queue keeps taking beats while the engine works or a
// result waits on m_axis; the engine holds a finished result until it can load
// the output register. Write the keys only while no block is in flight.
module ghash_accumulator_unit #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Input blocks
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [gha_pkg::GH_W-1:0]          s_axis_tdata,  // [63:0] block_high, [127:64] block_low
    input  logic                              s_axis_tuser,  // [0] start_req
    // Digests
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [gha_pkg::GH_W-1:0]          m_axis_tdata,  // [63:0] digest_high, [127:64] digest_low
    // Key writes
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [gha_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [gha_pkg::HALF_W-1:0]        i_cfg_data
);
    import gha_pkg::*;

    logic [HALF_W-1:0]  r_key_high;
    logic [HALF_W-1:0]  r_key_low;
    t_gh_item           in_item;
    t_gh_item           q_item;
    logic               q_valid;
    logic               q_pop;
    logic [GH_W-1:0]    digest;

    // Key writes are always taken; indexes beyond the key halves are dropped.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_high <= '0;
            r_key_low  <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_KEY_HIGH: r_key_high <= i_cfg_data;
                CFG_KEY_LOW:  r_key_low  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Internally a block is one 128-bit word with byte 0 in the top bits.
    assign in_item.block = {s_axis_tdata[HALF_W-1:0], s_axis_tdata[GH_W-1:HALF_W]};
    assign in_item.start = s_axis_tuser;

    gha_in_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_item  (in_item),
        .o_valid (q_valid),
        .i_pop   (q_pop),
        .o_item  (q_item)
    );

    gha_mult_engine u_engine (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_valid (q_valid),
        .i_item       (q_item),
        .o_pop        (q_pop),
        .i_key        ({r_key_high, r_key_low}),
        .o_valid      (m_axis_tvalid),
        .i_ready      (m_axis_tready),
        .o_digest     (digest)
    );

    // Swap halves back to the bus order: high half in the low tdata bits.
    assign m_axis_tdata = {digest[HALF_W-1:0], digest[GH_W-1:HALF_W]};

endmodule

FILE: hw/rtl/gha_in_queue.sv
// Front end of the GHASH accumulator: a short FIFO of incoming data blocks.
// Depends on gha_pkg for the queued item type.
module gha_in_queue #(
    parameter int DEPTH = 2
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  gha_pkg::t_gh_item i_item,
    output logic              o_valid,
    input  logic              i_pop,
    output gha_pkg::t_gh_item o_item
);
    import gha_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_gh_item           r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0]   r_count,  n_count;
    logic               push;
    logic               pop;

    assign o_ready = (r_count != CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign push    = i_valid && o_ready;
    assign pop     = i_pop && o_valid;
    assign o_item  = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (push && !pop) begin
            n_count = r_count + 1'b1;
        end else if (pop && !push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("input queue count above depth");

    a_fill_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push && !pop |=> r_count == $past(r_count) + 1'b1)
        else $error("input queue count did not advance on push");

    a_ptr_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) |-> (r_wr_ptr == r_rd_ptr))
        else $error("input queue pointers apart while empty");

endmodule

FILE: hw/rtl/gha_mult_engine.sv
// Back end of the GHASH accumulator: digit-serial GF(2^128) multiply, accumulator
// and output register. Depends on gha_pkg for the digit step, item type and states.
module gha_mult_engine (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_item_valid,
    input  gha_pkg::t_gh_item         i_item,
    output logic                      o_pop,
    input  logic [gha_pkg::GH_W-1:0]  i_key,
    output logic                      o_valid,
    input  logic                      i_ready,
    output logic [gha_pkg::GH_W-1:0]  o_digest
);
    import gha_pkg::*;

    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(N_DIGITS - 1);

    t_eng_state         r_state, n_state;
    logic [STEP_W-1:0]  r_cnt;
    logic [GH_W-1:0]    r_x;
    logic [GH_W-1:0]    r_z;
    logic [GH_W-1:0]    r_v;
    logic [GH_W-1:0]    r_acc;
    logic               r_out_valid;
    logic [GH_W-1:0]    r_out_data;

    t_gf_pair           step;
    logic               last;
    logic               out_free;
    logic               load_out;
    logic [GH_W-1:0]    acc_src;
    logic [GH_W-1:0]    x_start;

    assign step     = gf_digit(r_z, r_v, r_x[GH_W-1 -: DIGIT_W]);
    assign last     = (r_state == ST_BUSY) && (r_cnt == LAST_STEP);
    assign out_free = !r_out_valid || i_ready;
    // The finishing product bypasses r_acc so the next block can start at once.
    assign acc_src  = (r_state == ST_BUSY) ? step.z : r_acc;
    assign x_start  = (i_item.start ? '0 : acc_src) ^ i_item.block;

    always_comb begin
        n_state = ST_IDLE;
        case (r_state)
            ST_IDLE: begin
                n_state = i_item_valid ? ST_BUSY : ST_IDLE;
            end
            ST_BUSY: begin
                if (!last) begin
                    n_state = ST_BUSY;
                end else if (!out_free) begin
                    n_state = ST_WAIT;
                end else begin
                    n_state = i_item_valid ? ST_BUSY : ST_IDLE;
                end
            end
            ST_WAIT: begin
                if (!out_free) begin
                    n_state = ST_WAIT;
                end else begin
                    n_state = i_item_valid ? ST_BUSY : ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_pop    = 1'b0;
        load_out = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_pop = i_item_valid;
            end
            ST_BUSY: begin
                load_out = last && out_free;
                o_pop    = last && out_free && i_item_valid;
            end
            ST_WAIT: begin
                load_out = out_free;
                o_pop    = out_free && i_item_valid;
            end
            default: begin
                o_pop    = 1'b0;
                load_out = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_acc       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            // Clear on the final digit so the counter rests at zero outside a multiply.
            if (o_pop || last) begin
                r_cnt <= '0;
            end else if (r_state == ST_BUSY) begin
                r_cnt <= r_cnt + 1'b1;
            end
            if (last) begin
                r_acc <= step.z;
            end
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_x <= x_start;
            r_z <= '0;
            r_v <= i_key;
        end else if ((r_state == ST_BUSY) && !last) begin
            r_x <= r_x << DIGIT_W;
            r_z <= step.z;
            r_v <= step.v;
        end
        if (load_out) begin
            r_out_data <= acc_src;
        end
    end

    assign o_valid  = r_out_valid;
    assign o_digest = r_out_data;

    a_idle_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_BUSY) |-> (r_cnt == '0))
        else $error("digit counter running outside a multiply");

    a_pop_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> !((r_state == ST_BUSY) && (r_cnt != LAST_STEP)))
        else $error("new block taken in the middle of a multiply");

    a_out_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(last) || ($past(r_state) == ST_WAIT)))
        else $error("result loaded without a finished multiply");

endmodule

FILE: bench/ghash_digest_checker.sv
// Digest checker for the GHASH accumulator bench: tracks key writes and input beats,
// computes the expected digest of every block and compares it with each output beat.
// Depends on gha_pkg for widths and register indexes.
`timescale 1ns / 1ps

module ghash_digest_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_blk_valid,
    input  logic                            i_blk_ready,
    input  logic [gha_pkg::GH_W-1:0]        i_blk_data,
    input  logic                            i_blk_start,
    input  logic                            i_dig_valid,
    input  logic                            i_dig_ready,
    input  logic [gha_pkg::GH_W-1:0]        i_dig_data,
    input  logic                            i_cfg_valid,
    input  logic                            i_cfg_ready,
    input  logic [gha_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [gha_pkg::HALF_W-1:0]      i_cfg_data,
    output int                              o_mismatches,
    output int                              o_pending,
    output int                              o_checked
);
    import gha_pkg::*;

    // GCM reduction: 0xE1 followed by 120 zero bits, bit-reflected order.
    localparam logic [GH_W-1:0] REDUCE_POLY = {8'b11100001, 120'b0};

    typedef struct packed {
        logic [HALF_W-1:0] high;
        logic [HALF_W-1:0] low;
    } t_digest;

    t_digest           expected_digests[$];
    logic [HALF_W-1:0] key_high;
    logic [HALF_W-1:0] key_low;
    logic [HALF_W-1:0] acc_high;
    logic [HALF_W-1:0] acc_low;
    int                mismatch_count = 0;
    int                digest_count = 0;

    assign o_mismatches = mismatch_count;
    assign o_checked    = digest_count;

    // Field product x * h; field bit 0 is bit 127 of the packed value.
    function automatic logic [GH_W-1:0] gcm_field_mul(input logic [GH_W-1:0] x,
                                                      input logic [GH_W-1:0] h);
        logic [GH_W-1:0] z;
        logic [GH_W-1:0] v;
        logic            lsb;
        z = '0;
        v = h;
        for (int i = 0; i < GH_W; i++) begin
            if (x[GH_W-1-i]) begin
                z = z ^ v;
            end
            lsb = v[0];
            v   = v >> 1;
            if (lsb) begin
                v = v ^ REDUCE_POLY;
            end
        end
        return z;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("mismatch: %s", msg);
        mismatch_count++;
    endtask

    always @(posedge i_clk) begin
        logic [GH_W-1:0] product;
        t_digest         want;
        if (!i_rst_n) begin
            key_high = '0;
            key_low  = '0;
            acc_high = '0;
            acc_low  = '0;
            expected_digests.delete();
            o_pending <= 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_KEY_HIGH: key_high = i_cfg_data;
                    CFG_KEY_LOW:  key_low  = i_cfg_data;
                    default: ;  // drop writes to unused indexes
                endcase
            end
            if (i_blk_valid && i_blk_ready) begin
                if (i_blk_start) begin
                    acc_high = '0;
                    acc_low  = '0;
                end
                product = gcm_field_mul({acc_high ^ i_blk_data[HALF_W-1:0],
                                         acc_low ^ i_blk_data[GH_W-1:HALF_W]},
                                        {key_high, key_low});
                {acc_high, acc_low} = product;
                expected_digests.push_back(product);
            end
            if (i_dig_valid && i_dig_ready) begin
                if (expected_digests.size() == 0) begin
                    report_mismatch($sformatf("digest beat %h with no block waiting",
                                              i_dig_data));
                end else begin
                    want = expected_digests.pop_front();
                    if (i_dig_data[HALF_W-1:0] !== want.high) begin
                        report_mismatch($sformatf(
                            "digest_high of digest %0d: got %h, expected %h",
                            digest_count, i_dig_data[HALF_W-1:0], want.high));
                    end
                    if (i_dig_data[GH_W-1:HALF_W] !== want.low) begin
                        report_mismatch($sformatf(
                            "digest_low of digest %0d: got %h, expected %h",
                            digest_count, i_dig_data[GH_W-1:HALF_W], want.low));
                    end
                    digest_count++;
                end
            end
            o_pending <= expected_digests.size();
        end
    end

endmodule

FILE: bench/tb_ghash_accumulator_unit.sv
// Top of the GHASH accumulator bench: clock, reset, block and key stimulus, verdict.
// Depends on gha_pkg, ghash_accumulator_unit and ghash_digest_checker.
`timescale 1ns / 1ps

module tb_ghash_accumulator_unit;
    import gha_pkg::*;

    localparam int IDLE_PCT         = 8;
    localparam int STALL_LIMIT      = 2000;  // cycles without any beat
    localparam int SETTLE_CYCLES    = 24;    // idle time after the last digest
    localparam int RANDOM_PHASES    = 6;
    localparam int BLOCKS_PER_PHASE = 222;
    localparam int QUIET_PHASE      = 2;     // phase run with no idling on either side

    // Indexes the block does not decode; writes to them must be dropped.
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

    localparam logic [HALF_W-1:0] ALL_ONES = '1;
    localparam logic [HALF_W-1:0] TOP_BIT  = {1'b1, 63'b0};

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [GH_W-1:0]      s_axis_tdata = '0;
    logic                 s_axis_tuser = 1'b0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [GH_W-1:0]      m_axis_tdata;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [HALF_W-1:0]    i_cfg_data = '0;

    int mismatches;
    int pending;
    int checked;
    int idle_pct = IDLE_PCT;
    int blocks_sent = 0;
    int key_loads = 0;
    int stall_cycles = 0;

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    ghash_accumulator_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),   // [63:0] block_high, [127:64] block_low
        .s_axis_tuser  (s_axis_tuser),   // [0] start_req
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),   // [63:0] digest_high, [127:64] digest_low
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    ghash_digest_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_blk_valid  (s_axis_tvalid),
        .i_blk_ready  (s_axis_tready),
        .i_blk_data   (s_axis_tdata),
        .i_blk_start  (s_axis_tuser),
        .i_dig_valid  (m_axis_tvalid),
        .i_dig_ready  (m_axis_tready),
        .i_dig_data   (m_axis_tdata),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_mismatches (mismatches),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    // Stall the digest side at random; idle_pct drops to zero in the quiet phase.
    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(0, 99) >= idle_pct);
    end

    // Watchdog: end the run if no beat moves on any channel for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || (i_cfg_valid && o_cfg_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("timeout: no beat for %0d cycles, %0d digests outstanding",
                     STALL_LIMIT, pending);
            $display("status: fail");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // Mostly random words, with the extremes and single-bit values mixed in.
    function automatic logic [HALF_W-1:0] pick_word();
        case ($urandom_range(0, 15))
            0:       return ALL_ONES;
            1:       return '0;
            2:       return TOP_BIT >> $urandom_range(0, HALF_W-1);
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // Present one block beat, with a random gap first; hold valid high across
    // back-to-back beats.
    task automatic send_block(input logic [HALF_W-1:0] blk_high,
                              input logic [HALF_W-1:0] blk_low, input logic start);
        while ($urandom_range(0, 99) < idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {blk_low, blk_high};
        s_axis_tuser  <= start;
        do @(posedge i_clk); while (!s_axis_tready);
        blocks_sent++;
    endtask

    // Leaves valid high; the caller lowers it after the last write of a group.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [HALF_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    task automatic load_key(input logic [HALF_W-1:0] key_high, input logic [HALF_W-1:0] key_low);
        write_reg(CFG_KEY_HIGH, key_high);
        write_reg(CFG_KEY_LOW, key_low);
        i_cfg_valid <= 1'b0;
        key_loads++;
    endtask

    // Drop valid, wait for every digest, then give the engine time to go idle.
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        logic start;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Key is zero out of reset: every digest must be zero.
        send_block(ALL_ONES, ALL_ONES, 1'b1);
        send_block(pick_word(), pick_word(), 1'b0);
        send_block('0, '0, 1'b0);
        settle();

        // Writes to unused indexes must not touch the key.
        write_reg(CFG_SPARE_A, ALL_ONES);
        write_reg(CFG_SPARE_B, ALL_ONES);
        i_cfg_valid <= 1'b0;
        send_block(ALL_ONES, pick_word(), 1'b1);
        settle();

        // H = 1 in the field: the digest is the running XOR of the blocks.
        load_key(TOP_BIT, '0);
        send_block(ALL_ONES, ALL_ONES, 1'b1);
        send_block('0, '0, 1'b0);
        send_block({32{2'b10}}, {32{2'b01}}, 1'b0);
        send_block('0, 64'd1, 1'b1);
        send_block(TOP_BIT, '0, 1'b0);
        send_block(ALL_ONES, '0, 1'b0);
        settle();

        // All-ones key.
        load_key(ALL_ONES, ALL_ONES);
        send_block(ALL_ONES, ALL_ONES, 1'b1);
        send_block(ALL_ONES, ALL_ONES, 1'b0);
        send_block('0, '0, 1'b0);
        send_block(pick_word(), pick_word(), 1'b1);
        settle();

        // Key with only the last field bit set, without a start: the accumulator carries over.
        load_key('0, 64'd1);
        send_block(ALL_ONES, ALL_ONES, 1'b0);
        send_block(ALL_ONES, '0, 1'b1);
        send_block('0, ALL_ONES, 1'b0);
        send_block(pick_word(), pick_word(), 1'b0);
        settle();

        // Random keys and messages; starts at random split each phase into messages.
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            idle_pct = (p == QUIET_PHASE) ? 0 : IDLE_PCT;
            write_reg($urandom_range(0, 1) ? CFG_SPARE_A : CFG_SPARE_B, pick_word());
            if (p == 0) begin
                load_key({$urandom, $urandom}, {$urandom, $urandom});
            end else begin
                load_key(pick_word(), pick_word());
            end
            for (int n = 0; n < BLOCKS_PER_PHASE; n++) begin
                start = (p == 0 && n == 0) || ($urandom_range(0, 7) == 0);
                send_block(pick_word(), pick_word(), start);
            end
            settle();
        end

        $display("sent %0d blocks, checked %0d digests under %0d key loads",
                 blocks_sent, checked, key_loads);
        $display("random traffic ran %0d phases, one without any idling", RANDOM_PHASES);
        if (mismatches == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
